// ===== rtl/c3t_pkg.sv =====
// ----------------------------------------------------------------------------
// c3t_pkg
// Shared widths, constants and the queue word of the 3x3 Cramer solver.
// ----------------------------------------------------------------------------
package c3t_pkg;

    localparam int ELEM_W      = 16;
    localparam int FRAC_BITS   = 8;
    localparam int OUT_FRAC    = 16;
    localparam int DET_W       = 3 * ELEM_W + 1;
    localparam int MAG_W       = DET_W - 1;
    localparam int OUT_W       = 32;
    localparam int SHIFT_W     = 6;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd40;
    localparam int IN_DATA_W   = 12 * ELEM_W;
    localparam int OUT_DATA_W  = ((3 * OUT_W + DET_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [DET_W-1:0] num2;
        logic signed [DET_W-1:0] num1;
        logic signed [DET_W-1:0] num0;
        logic signed [DET_W-1:0] det;
        logic                    solved;
    } c3t_job_t;

endpackage

// ===== rtl/c3t_front.sv =====
// ----------------------------------------------------------------------------
// c3t_front
// Five-stage pipeline: cofactors, Cramer numerators, determinant, norm and
// the singularity test against the tolerance shift.
// ----------------------------------------------------------------------------
module c3t_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [c3t_pkg::IN_DATA_W-1:0]       in_data,
    input  logic [c3t_pkg::SHIFT_W-1:0]         shift,
    input  logic                                q_full,
    output logic                                push,
    output c3t_pkg::c3t_job_t                   job
);

    localparam int PROD_W = 2 * c3t_pkg::ELEM_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int NORM_W = PROD_W + 2;
    localparam int REF_W  = NORM_W + c3t_pkg::FRAC_BITS;
    localparam int WIDE_W = c3t_pkg::MAG_W + REF_W;
    localparam int SHIFT_LIMIT = REF_W + 1;

    logic [4:0] v_reg;
    logic       en;

    logic signed [c3t_pkg::ELEM_W-1:0] ain [3][3];
    logic signed [c3t_pkg::ELEM_W-1:0] bin [3];

    logic signed [PROD_W-1:0] pa_reg [3][3];
    logic signed [PROD_W-1:0] pb_reg [3][3];
    logic signed [PROD_W-1:0] sq_reg [3][3];
    logic signed [c3t_pkg::ELEM_W-1:0] a1_reg [3];
    logic signed [c3t_pkg::ELEM_W-1:0] b1_reg [3];

    logic signed [COF_W-1:0] cof_reg [3][3];
    logic [NORM_W-1:0] nrow_reg [3];
    logic signed [c3t_pkg::ELEM_W-1:0] a2_reg [3];
    logic signed [c3t_pkg::ELEM_W-1:0] b2_reg [3];

    logic signed [c3t_pkg::DET_W-1:0] tp_reg [3][3];
    logic signed [c3t_pkg::DET_W-1:0] td_reg [3];
    logic [NORM_W-1:0] norm3_reg;

    logic signed [c3t_pkg::DET_W-1:0] num4_reg [3];
    logic signed [c3t_pkg::DET_W-1:0] det4_reg;
    logic [NORM_W-1:0] norm4_reg;

    c3t_pkg::c3t_job_t job_reg;

    logic [c3t_pkg::MAG_W-1:0] ad;
    logic [WIDE_W-1:0]         wide;
    logic [WIDE_W-1:0]         ref_val;
    logic                      sing;

    function automatic int oth(input int i, input int n);
        if (n == 0)
            return (i == 0) ? 1 : 0;
        else
            return (i == 2) ? 1 : 2;
    endfunction

    assign en       = !v_reg[4] || !q_full;
    assign in_ready = en;
    assign push     = v_reg[4] && !q_full;
    assign job      = job_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                ain[i][j] = in_data[(i*3+j)*c3t_pkg::ELEM_W +: c3t_pkg::ELEM_W];
            bin[i] = in_data[(9+i)*c3t_pkg::ELEM_W +: c3t_pkg::ELEM_W];
        end
    end

    // Singularity test: a shifted magnitude beyond the norm range is never below it.
    always_comb
    begin
        ad      = det4_reg[c3t_pkg::DET_W-1] ? c3t_pkg::MAG_W'(-det4_reg)
                                             : c3t_pkg::MAG_W'(det4_reg);
        wide    = WIDE_W'(ad) << shift;
        ref_val = WIDE_W'({norm4_reg, {c3t_pkg::FRAC_BITS{1'b0}}});
        sing    = (norm4_reg == '0) || (ad == '0)
               || ((32'(shift) < SHIFT_LIMIT) && (wide < ref_val));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pa_reg[i][j] <= ain[oth(i,0)][oth(j,0)] * ain[oth(i,1)][oth(j,1)];
                    pb_reg[i][j] <= ain[oth(i,0)][oth(j,1)] * ain[oth(i,1)][oth(j,0)];
                    sq_reg[i][j] <= ain[i][j] * ain[i][j];
                end
                a1_reg[i] <= ain[0][i];
                b1_reg[i] <= bin[i];
            end

            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    if (((i + j) & 1) != 0)
                        cof_reg[i][j] <= COF_W'(pb_reg[i][j]) - COF_W'(pa_reg[i][j]);
                    else
                        cof_reg[i][j] <= COF_W'(pa_reg[i][j]) - COF_W'(pb_reg[i][j]);
                end
                nrow_reg[i] <= {2'b00, sq_reg[i][0]} + {2'b00, sq_reg[i][1]}
                             + {2'b00, sq_reg[i][2]};
                a2_reg[i] <= a1_reg[i];
                b2_reg[i] <= b1_reg[i];
            end

            // Numerator k expands along column k with the right-hand side.
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                    tp_reg[k][i] <= b2_reg[i] * cof_reg[i][k];
                td_reg[k] <= a2_reg[k] * cof_reg[0][k];
            end
            norm3_reg <= nrow_reg[0] + nrow_reg[1] + nrow_reg[2];

            for (int k = 0; k < 3; k++)
                num4_reg[k] <= tp_reg[k][0] + tp_reg[k][1] + tp_reg[k][2];
            det4_reg  <= td_reg[0] + td_reg[1] + td_reg[2];
            norm4_reg <= norm3_reg;

            job_reg.num0   <= num4_reg[0];
            job_reg.num1   <= num4_reg[1];
            job_reg.num2   <= num4_reg[2];
            job_reg.det    <= det4_reg;
            job_reg.solved <= !sing;
        end
    end

endmodule

// ===== rtl/c3t_queue.sv =====
// ----------------------------------------------------------------------------
// c3t_queue
// Four-entry queue of solve jobs between the front and the divider pipeline.
// ----------------------------------------------------------------------------
module c3t_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  c3t_pkg::c3t_job_t wr_job,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output c3t_pkg::c3t_job_t rd_job
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    c3t_pkg::c3t_job_t mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_job    = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

// ===== rtl/c3t_back.sv =====
// ----------------------------------------------------------------------------
// c3t_back
// Three restoring dividers, one quotient bit per stage, with rounding,
// saturation and the output register.
// ----------------------------------------------------------------------------
module c3t_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 job_valid,
    input  c3t_pkg::c3t_job_t                    job,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [c3t_pkg::OUT_W-1:0]            x0,
    output logic [c3t_pkg::OUT_W-1:0]            x1,
    output logic [c3t_pkg::OUT_W-1:0]            x2,
    output logic [c3t_pkg::DET_W-1:0]            determinant,
    output logic                                 solved
);

    // Quotient bits kept; anything from 2^35 up is flagged as overflow.
    localparam int QBITS  = c3t_pkg::OUT_W + 3;
    localparam int OVF_SH = QBITS - c3t_pkg::OUT_FRAC - 1;
    localparam int R_W    = c3t_pkg::MAG_W + 2;
    localparam int NS     = QBITS;
    localparam int CMP_W  = c3t_pkg::MAG_W + OVF_SH;

    typedef struct packed {
        logic [R_W-1:0]              r;
        logic [c3t_pkg::MAG_W-1:0]   d;
        logic [QBITS-1:0]            q;
        logic [QBITS-1:0]            nd;
        logic                        neg;
        logic                        ovf;
    } lane_t;

    lane_t lane_reg [NS+1][3];
    lane_t lane_next [NS+1][3];
    logic  sol_reg [NS+1];
    logic signed [c3t_pkg::DET_W-1:0] det_reg [NS+1];
    logic [NS:0] vld_reg;

    logic                         out_valid_reg;
    logic [c3t_pkg::OUT_W-1:0]    x_reg [3];
    logic [c3t_pkg::DET_W-1:0]    det_out_reg;
    logic                         solved_reg;
    logic                         en;

    logic signed [c3t_pkg::DET_W-1:0] nums [3];

    function automatic lane_t load(input logic signed [c3t_pkg::DET_W-1:0] num,
                                   input logic signed [c3t_pkg::DET_W-1:0] den);
        lane_t l;
        logic [c3t_pkg::MAG_W-1:0] n;
        n     = num[c3t_pkg::DET_W-1] ? c3t_pkg::MAG_W'(-num) : c3t_pkg::MAG_W'(num);
        l.d   = den[c3t_pkg::DET_W-1] ? c3t_pkg::MAG_W'(-den) : c3t_pkg::MAG_W'(den);
        l.neg = num[c3t_pkg::DET_W-1] != den[c3t_pkg::DET_W-1];
        l.ovf = CMP_W'(n) >= {l.d, {OVF_SH{1'b0}}};
        l.r   = R_W'(n >> OVF_SH);
        l.nd  = QBITS'(n << (c3t_pkg::OUT_FRAC + 1));
        l.q   = '0;
        return l;
    endfunction

    function automatic lane_t step(input lane_t p);
        lane_t l;
        logic [R_W-1:0] rt;
        l  = p;
        rt = {p.r[R_W-2:0], p.nd[QBITS-1]};
        if (rt >= R_W'(p.d))
        begin
            l.r = rt - R_W'(p.d);
            l.q = {p.q[QBITS-2:0], 1'b1};
        end
        else
        begin
            l.r = rt;
            l.q = {p.q[QBITS-2:0], 1'b0};
        end
        l.nd = p.nd << 1;
        return l;
    endfunction

    // Round half away from zero, then saturate to the signed 32-bit range.
    function automatic logic [c3t_pkg::OUT_W-1:0] finish(input lane_t l, input logic ok);
        logic [QBITS:0]   q1;
        logic [QBITS-1:0] m;
        logic [QBITS-1:0] pos_max;
        logic [QBITS-1:0] neg_max;
        logic [c3t_pkg::OUT_W-1:0] res;
        pos_max = QBITS'({1'b0, {(c3t_pkg::OUT_W-1){1'b1}}});
        neg_max = QBITS'({1'b1, {(c3t_pkg::OUT_W-1){1'b0}}});
        q1 = {1'b0, l.q} + 1'b1;
        m  = q1[QBITS:1];
        if (l.neg)
        begin
            if (l.ovf || (m > neg_max))
                m = neg_max;
            res = c3t_pkg::OUT_W'(-m);
        end
        else
        begin
            if (l.ovf || (m > pos_max))
                m = pos_max;
            res = c3t_pkg::OUT_W'(m);
        end
        return ok ? res : '0;
    endfunction

    assign en  = !out_valid_reg || out_ready;
    assign pop = job_valid && en;

    assign nums[0] = job.num0;
    assign nums[1] = job.num1;
    assign nums[2] = job.num2;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lane_next[0][k] = load(nums[k], job.det);
            for (int s = 1; s <= NS; s++)
                lane_next[s][k] = step(lane_reg[s-1][k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NS-1:0], pop};
            out_valid_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= NS; s++)
                for (int k = 0; k < 3; k++)
                    lane_reg[s][k] <= lane_next[s][k];
            sol_reg[0] <= job.solved;
            det_reg[0] <= job.det;
            for (int s = 1; s <= NS; s++)
            begin
                sol_reg[s] <= sol_reg[s-1];
                det_reg[s] <= det_reg[s-1];
            end
            for (int k = 0; k < 3; k++)
                x_reg[k] <= finish(lane_reg[NS][k], sol_reg[NS]);
            det_out_reg <= det_reg[NS];
            solved_reg  <= sol_reg[NS];
        end
    end

    assign out_valid   = out_valid_reg;
    assign x0          = x_reg[0];
    assign x1          = x_reg[1];
    assign x2          = x_reg[2];
    assign determinant = det_out_reg;
    assign solved      = solved_reg;

endmodule

// ===== rtl/solve_3x3_cramer_with_tolerance_unit.sv =====
// Throughput: one matrix per cycle while the output is not stalled, set by the one-bit-per-stage divider pipeline.
// Each of the 35 divider stages retires one quotient bit of all three unknowns.
// A four-word queue lets the front keep accepting while the output is briefly stalled.
// Reset empties every pipeline stage and the queue and sets the tolerance shift (shift_reg) to 40.
// ----------------------------------------------------------------------------
// solve_3x3_cramer_with_tolerance_unit
// Streaming 3x3 linear solver by Cramer's rule with a singularity tolerance.
// ----------------------------------------------------------------------------
module solve_3x3_cramer_with_tolerance_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22 rhs0 rhs1 rhs2, 16 bits each
    input  logic [c3t_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // x0, x1, x2 (32 bits each), determinant (49 bits), zero fill
    output logic [c3t_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // solved
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [c3t_pkg::SHIFT_W-1:0]       cfg_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready
);

    localparam int PAD_W = c3t_pkg::OUT_DATA_W - 3 * c3t_pkg::OUT_W - c3t_pkg::DET_W;

    logic [c3t_pkg::SHIFT_W-1:0] shift_reg;
    logic                        q_full;
    logic                        push;
    logic                        pop;
    logic                        q_valid;
    c3t_pkg::c3t_job_t           front_job;
    c3t_pkg::c3t_job_t           queue_job;
    logic [c3t_pkg::OUT_W-1:0]   x0;
    logic [c3t_pkg::OUT_W-1:0]   x1;
    logic [c3t_pkg::OUT_W-1:0]   x2;
    logic [c3t_pkg::DET_W-1:0]   determinant;
    logic                        solved;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shift_reg <= c3t_pkg::SHIFT_RESET;
        else if (cfg_valid)
            shift_reg <= cfg_data;
    end

    c3t_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .shift    (shift_reg),
        .q_full   (q_full),
        .push     (push),
        .job      (front_job)
    );

    c3t_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_job    (front_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .rd_job    (queue_job)
    );

    c3t_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job         (queue_job),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .x0          (x0),
        .x1          (x1),
        .x2          (x2),
        .determinant (determinant),
        .solved      (solved)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, determinant, x2, x1, x0};
    assign m_axis_tuser = solved;

endmodule

// ===== rtl/c3t_checker.sv =====
// ----------------------------------------------------------------------------
// c3t_checker
// Port-level checks of the solver, attached to the top level by bind.
// ----------------------------------------------------------------------------
module c3t_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic [c3t_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic [0:0]                        m_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready
);

    // A stalled result word holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    // A singular result carries zero unknowns.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0]
        |-> m_axis_tdata[3*c3t_pkg::OUT_W-1:0] == '0)
        else $error("singular result with nonzero unknowns");

    // A zero determinant is never judged solvable.
    a_det: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3*c3t_pkg::OUT_W +: c3t_pkg::DET_W] == '0
        |-> !m_axis_tuser[0])
        else $error("zero determinant reported as solved");

    // Nothing leaves the block in the cycle after reset is released.
    a_rst: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result word right after reset");

endmodule

bind solve_3x3_cramer_with_tolerance_unit c3t_checker u_checker (.*);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 3x3 Cramer solver. A directed table
// of matrices runs first, then random phases under several tolerance shifts,
// with random gaps on the input side and random stalls on the output side.
// Every result word is compared with a bit-exact prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM   = 850;
    localparam int  DRAIN_WAIT = 60;
    localparam int  MAX_GAP    = 6;

    typedef struct {
        logic signed [c3t_pkg::OUT_W-1:0] x0;
        logic signed [c3t_pkg::OUT_W-1:0] x1;
        logic signed [c3t_pkg::OUT_W-1:0] x2;
        logic signed [c3t_pkg::DET_W-1:0] det;
        logic                             solved;
    } solution_t;

    typedef struct {
        logic [c3t_pkg::IN_DATA_W-1:0] word;
        bit                            typed;
        solution_t                     sol;
    } matrix_row_t;

    logic                              clk;
    logic                              rst_n;
    logic [c3t_pkg::IN_DATA_W-1:0]     s_axis_tdata;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [c3t_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic [0:0]                        m_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [c3t_pkg::SHIFT_W-1:0]       cfg_data;
    logic                              cfg_valid;
    logic                              cfg_ready;

    solution_t                         pending_solutions[$];
    logic [c3t_pkg::SHIFT_W-1:0]       shift_now;
    int                                fail_count;
    int                                words_checked;
    int                                solved_seen;
    bit                                no_idle;

    solve_3x3_cramer_with_tolerance_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint det3(input longint a0, a1, a2, a3, a4, a5, a6, a7, a8);
        return a0 * (a4 * a8 - a5 * a7) - a1 * (a3 * a8 - a5 * a6) + a2 * (a3 * a7 - a4 * a6);
    endfunction

    // Q24.24 over Q24.24 into Q16.16, rounded half away from zero, saturated.
    function automatic logic [c3t_pkg::OUT_W-1:0] cramer_ratio(input longint num,
                                                               input longint den);
        logic [127:0]        n;
        logic [127:0]        d;
        logic [127:0]        q;
        longint unsigned     m;
        bit                  neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? 128'(-num) : 128'(num);
        d = (den < 0) ? 128'(-den) : 128'(den);
        q = (n << (c3t_pkg::OUT_FRAC + 1)) / d;
        if (q > (128'd1 << 40))
            q = 128'd1 << 40;
        m = 64'(q + 1) >> 1;
        if (neg)
        begin
            if (m > 64'h8000_0000)
                m = 64'h8000_0000;
            return c3t_pkg::OUT_W'(-m);
        end
        if (m > 64'h7FFF_FFFF)
            m = 64'h7FFF_FFFF;
        return c3t_pkg::OUT_W'(m);
    endfunction

    function automatic solution_t solve_cramer(input logic [c3t_pkg::IN_DATA_W-1:0] word,
                                               input logic [c3t_pkg::SHIFT_W-1:0] shift);
        longint            e[12];
        longint            dt;
        longint            n0;
        longint            n1;
        longint            n2;
        longint unsigned   nrm;
        longint unsigned   ad;
        bit                singular;
        solution_t         s;
        nrm = 0;
        for (int i = 0; i < 12; i++)
        begin
            e[i] = longint'($signed(word[i*c3t_pkg::ELEM_W +: c3t_pkg::ELEM_W]));
            if (i < 9)
                nrm += longint'(e[i] * e[i]);
        end
        dt = det3(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
        n0 = det3(e[9], e[1], e[2], e[10], e[4], e[5], e[11], e[7], e[8]);
        n1 = det3(e[0], e[9], e[2], e[3], e[10], e[5], e[6], e[11], e[8]);
        n2 = det3(e[0], e[1], e[9], e[3], e[4], e[10], e[6], e[7], e[11]);
        ad = (dt < 0) ? longint'(-dt) : longint'(dt);
        if (nrm == 0 || ad == 0)
            singular = 1'b1;
        else if (shift >= 63 || ad > (64'hFFFF_FFFF_FFFF_FFFF >> shift))
            singular = 1'b0;
        else
            singular = (ad << shift) < (nrm << c3t_pkg::FRAC_BITS);
        s.x0     = singular ? '0 : cramer_ratio(n0, dt);
        s.x1     = singular ? '0 : cramer_ratio(n1, dt);
        s.x2     = singular ? '0 : cramer_ratio(n2, dt);
        s.det    = c3t_pkg::DET_W'(dt);
        s.solved = !singular;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [c3t_pkg::IN_DATA_W-1:0] pack_matrix(input int a0, a1, a2, a3,
                                                                  a4, a5, a6, a7, a8,
                                                                  b0, b1, b2);
        return {16'(b2), 16'(b1), 16'(b0), 16'(a8), 16'(a7), 16'(a6),
                16'(a5), 16'(a4), 16'(a3), 16'(a2), 16'(a1), 16'(a0)};
    endfunction

    function automatic int draw_entry(input int kind);
        case (kind)
            4, 5:    return int'($urandom_range(0, 1024)) - 512;
            8:       return int'($urandom_range(0, 6)) - 3;
            default: return int'(shortint'($urandom()));
        endcase
    endfunction

    function automatic logic [c3t_pkg::IN_DATA_W-1:0] random_matrix();
        int                             kind;
        int                             e[12];
        bit                             flip;
        logic [c3t_pkg::IN_DATA_W-1:0]  w;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
            e[i] = draw_entry(kind);
        if (kind == 6)
        begin
            // Third row a copy or a negation of the first: singular by rank.
            flip = ($urandom_range(0, 1) != 0);
            for (int j = 0; j < 3; j++)
                e[6 + j] = flip ? -e[j] : e[j];
        end
        else if (kind == 7)
        begin
            for (int i = 0; i < 9; i++)
                e[i] = (i % 4 == 0) ? int'($urandom_range(256, 32767))
                                    : int'($urandom_range(0, 64)) - 32;
        end
        else if (kind == 9)
        begin
            for (int i = 0; i < 12; i++)
                e[i] = e[i] >>> $urandom_range(0, 14);
        end
        w = pack_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8],
                        e[9], e[10], e[11]);
        return w;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    task automatic send_matrix(input logic [c3t_pkg::IN_DATA_W-1:0] word, input bit typed,
                               input solution_t sol);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_solutions.push_back(typed ? sol : solve_cramer(word, shift_now));
    endtask

    // Holds the input back until every word in flight has come out, then writes the new shift.
    task automatic drain_and_write_shift(input logic [c3t_pkg::SHIFT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shift_now  = value;
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("word %0d: %s got %0h expected %0h", words_checked, field, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls and the comparison
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        solution_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_solutions.size() == 0)
            begin
                report_mismatch("unexpected word", 64'(m_axis_tdata[95:0]), 64'd0);
            end
            else
            begin
                want = pending_solutions.pop_front();
                if (m_axis_tdata[31:0] !== want.x0)
                    report_mismatch("x0", 64'(m_axis_tdata[31:0]), 64'(want.x0));
                if (m_axis_tdata[63:32] !== want.x1)
                    report_mismatch("x1", 64'(m_axis_tdata[63:32]), 64'(want.x1));
                if (m_axis_tdata[95:64] !== want.x2)
                    report_mismatch("x2", 64'(m_axis_tdata[95:64]), 64'(want.x2));
                if (m_axis_tdata[96 +: c3t_pkg::DET_W] !== want.det)
                    report_mismatch("determinant", 64'(m_axis_tdata[96 +: c3t_pkg::DET_W]),
                                    64'(want.det));
                if (m_axis_tuser[0] !== want.solved)
                    report_mismatch("solved", 64'(m_axis_tuser[0]), 64'(want.solved));
                if (want.solved)
                    solved_seen++;
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        matrix_row_t                   matrix_table[$];
        matrix_row_t                   row;
        solution_t                     blank;
        logic [c3t_pkg::SHIFT_W-1:0]   shift_plan[6];
        logic [c3t_pkg::IN_DATA_W-1:0] w;

        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        cfg_data      = '0;
        cfg_valid     = 1'b0;
        shift_now     = c3t_pkg::SHIFT_RESET;
        fail_count    = 0;
        words_checked = 0;
        solved_seen   = 0;
        no_idle       = 1'b0;
        blank         = '{x0: '0, x1: '0, x2: '0, det: '0, solved: 1'b0};

        // Zero matrix, all singular-by-rank cases: typed outcome.
        row = '{pack_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, blank};
        matrix_table.push_back(row);
        row = '{pack_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, 32767, -32768, 1), 1'b1, blank};
        matrix_table.push_back(row);
        row = '{pack_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            -1, 0, 32767), 1'b1, blank};
        matrix_table.push_back(row);
        row = '{pack_matrix(256, 512, 768, 512, 1024, 1536, 1, 2, 3, 256, 256, 256),
                1'b1, blank};
        matrix_table.push_back(row);
        // Identity: unknowns are the right-hand side moved into Q16.16.
        row = '{pack_matrix(256, 0, 0, 0, 256, 0, 0, 0, 256, 256, 256, 256), 1'b1,
                '{x0: 32'sd65536, x1: 32'sd65536, x2: 32'sd65536, det: 49'sd16777216,
                  solved: 1'b1}};
        matrix_table.push_back(row);
        row = '{pack_matrix(256, 0, 0, 0, 256, 0, 0, 0, 256, -256, 0, 32767), 1'b1,
                '{x0: -32'sd65536, x1: 32'sd0, x2: 32'sd8388352, det: 49'sd16777216,
                  solved: 1'b1}};
        matrix_table.push_back(row);
        // The rest goes through the predictor.
        row.typed = 1'b0;
        row.word = pack_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767, 32767, -32768, 1);
        matrix_table.push_back(row);
        row.word = pack_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768, -32768, 32767, -1);
        matrix_table.push_back(row);
        row.word = pack_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1, 32767, -32768, 1);
        matrix_table.push_back(row);
        row.word = pack_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1, -32768, 32767, 0);
        matrix_table.push_back(row);
        row.word = pack_matrix(0, 256, 0, 256, 0, 0, 0, 0, 256, 100, -200, 300);
        matrix_table.push_back(row);
        row.word = pack_matrix(32767, -32768, 1, -1, 32767, -32768, 1, 1, 32767, 5, -7, 11);
        matrix_table.push_back(row);
        // Nearly dependent rows with a large norm: tolerance decides.
        row.word = pack_matrix(30000, 20000, 10000, 30000, 20000, 10001, 10000, 5000, 1,
                               -32768, 32767, 100);
        matrix_table.push_back(row);
        row.word = pack_matrix(32767, 32767, 32767, 32767, 32767, 32766, 32767, 32766, 32767,
                               1, 1, 1);
        matrix_table.push_back(row);
        row.word = pack_matrix(-32768, 32767, -32768, 32767, -32768, 32767, 0, 0, 1, 32767,
                               32767, -32768);
        matrix_table.push_back(row);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (matrix_table[i])
            send_matrix(matrix_table[i].word, matrix_table[i].typed, matrix_table[i].sol);

        shift_plan = '{6'd0, 6'd48, 6'd63, 6'd1, 6'd40, 6'd0};
        shift_plan[5] = c3t_pkg::SHIFT_W'($urandom_range(2, 62));
        for (int p = 0; p < 6; p++)
        begin
            drain_and_write_shift(shift_plan[p]);
            // One phase runs back to back on both sides.
            no_idle = (p == 3);
            for (int i = 0; i < N_RANDOM / 6 + 1; i++)
            begin
                w = random_matrix();
                send_matrix(w, 1'b0, blank);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d result words, %0d judged nonsingular, across six tolerance",
                 words_checked, solved_seen);
        $display("shifts including 0, 48 and 63, with gaps and stalls on both sides.");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/c3t_pkg.sv
rtl/c3t_front.sv
rtl/c3t_queue.sv
rtl/c3t_back.sv
rtl/solve_3x3_cramer_with_tolerance_unit.sv
rtl/c3t_checker.sv
test/tb_top.sv
